@@ sv/fixed_timeout_timer_list_macros.svh @@
// Assertion macros used by the checker of the fixed-timeout timer list.
`ifndef FIXED_TIMEOUT_TIMER_LIST_MACROS_SVH
`define FIXED_TIMEOUT_TIMER_LIST_MACROS_SVH

// Property checked at every rising edge outside reset.
`define FTL_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("timer list check failed");

// Implication checked on the same edge.
`define FTL_ASSERT_IMP(name, clk, rst_n, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("timer list check failed");

`endif

@@ sv/ftl_pkg.sv @@
// Types and constants of the fixed-timeout timer list.
`default_nettype none
package ftl_pkg;

	localparam int HANDLE_W    = 5;
	localparam int TIMEOUT_W   = 32;
	localparam int TIME_W      = 64;
	localparam int ARG_W       = 64;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_REMOVED = 3'd1,
		KIND_EXPIRED = 3'd2,
		KIND_CLEARED = 3'd3,
		KIND_NOTHING = 3'd4,
		KIND_ERROR   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RM_CHK,
		ST_RM_UL,
		ST_WALK,
		ST_CHK,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [HANDLE_W-1:0] handle;
		logic [ARG_W-1:0]    user_arg;
		logic [TIME_W-1:0]   now;
	} req_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [HANDLE_W-1:0] handle_res;
		logic [ARG_W-1:0]    user_arg_res;
		logic                last;
	} rsp_t;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic                handle_ok;
		logic [ARG_W-1:0]    user_arg;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   deadline;
	} cmd_t;

endpackage
`default_nettype wire

@@ sv/ftl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ftl_ram #(
	parameter int W = 64,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ sv/ftl_front.sv @@
// Front end: takes requests, checks the handle range and forms the deadline.
`default_nettype none
module ftl_front #(
	parameter int SLOTS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ftl_pkg::req_t                    req,
	input  logic [ftl_pkg::TIMEOUT_W-1:0]    timeout,
	output logic                             cmd_valid,
	input  logic                             cmd_ready,
	output ftl_pkg::cmd_t                    cmd
);
	import ftl_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;

	assign req_ready = !valid_s1 || cmd_ready;
	assign take      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op        <= op_t'(req.opcode);
			cmd_s1.handle    <= req.handle;
			cmd_s1.handle_ok <= (32'(req.handle) < 32'(SLOTS));
			cmd_s1.user_arg  <= req.user_arg;
			cmd_s1.now       <= req.now;
			cmd_s1.deadline  <= req.now + {{(TIME_W-TIMEOUT_W){1'b0}}, timeout};
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;
endmodule
`default_nettype wire

@@ sv/ftl_fifo.sv @@
// Short queue of classified requests between the front and back ends.
`default_nettype none
module ftl_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ftl_pkg::cmd_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ftl_pkg::cmd_t out_data
);
	import ftl_pkg::*;

	localparam int PW = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != (PW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

@@ sv/ftl_back.sv @@
// Back end: slot table, linked list sequencer and result register.
`default_nettype none
module ftl_back #(
	parameter int SLOTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ftl_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ftl_pkg::rsp_t rsp
);
	import ftl_pkg::*;

	localparam int IW = $clog2(SLOTS);

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	logic [SLOTS-1:0]   valid_q;
	logic [IW-1:0]      head_q, tail_q;
	logic               empty_q;
	logic [IW-1:0]      free_idx_q, free_idx_d;
	logic               free_any_q, free_any_d;
	logic [CNT_W-1:0]   cnt_q;
	rsp_t               pend_q, pend_d;
	logic               pend_v_q;
	rsp_t               rsp_q, push_d;
	logic               rsp_v_q;

	logic [ARG_W-1:0]   arg_rd;
	logic [TIME_W-1:0]  dl_rd;
	logic [IW-1:0]      nx_rd, pv_rd;

	logic               mem_we, mem_re;
	logic               nx_we, nx_re, pv_we, pv_re;
	logic [IW-1:0]      nx_waddr, nx_wdata, pv_waddr, pv_wdata, nx_raddr;
	logic               set_pend, push_mid, push_last;
	logic               add_go, rm_go, hd_go;

	logic [HANDLE_W+IW-1:0] hx, headx, freex;
	logic [IW-1:0]      cmd_idx;
	logic [HANDLE_W-1:0] head_h, free_h;
	logic               slot_live, out_free, stop, due, can_emit;

	assign hx      = {{IW{1'b0}}, cmd_q.handle};
	assign cmd_idx = hx[IW-1:0];
	assign headx   = {{HANDLE_W{1'b0}}, head_q};
	assign head_h  = headx[HANDLE_W-1:0];
	assign freex   = {{HANDLE_W{1'b0}}, free_idx_q};
	assign free_h  = freex[HANDLE_W-1:0];

	assign slot_live = cmd_q.handle_ok && valid_q[cmd_idx];
	assign out_free  = !rsp_v_q || rsp_ready;
	assign stop      = empty_q || (cnt_q == CNT_W'(MAX_RESULTS));
	assign due       = !((cmd_q.op == OP_TICK) && (cmd_q.now < dl_rd));
	assign can_emit  = !pend_v_q || out_free;

	// Lowest free slot, registered in the cycle after the valid bits change.
	always_comb begin
		free_idx_d = '0;
		free_any_d = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx_d = IW'(i);
				free_any_d = 1'b1;
			end
		end
	end

	ftl_ram #(.W(ARG_W), .D(SLOTS)) u_arg_ram (
		.clk(clk), .we(mem_we), .waddr(free_idx_q), .wdata(cmd_q.user_arg),
		.re(mem_re), .raddr(head_q), .rdata(arg_rd)
	);

	ftl_ram #(.W(TIME_W), .D(SLOTS)) u_dl_ram (
		.clk(clk), .we(mem_we), .waddr(free_idx_q), .wdata(cmd_q.deadline),
		.re(mem_re), .raddr(head_q), .rdata(dl_rd)
	);

	ftl_ram #(.W(IW), .D(SLOTS)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.re(nx_re), .raddr(nx_raddr), .rdata(nx_rd)
	);

	ftl_ram #(.W(IW), .D(SLOTS)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.re(pv_re), .raddr(cmd_idx), .rdata(pv_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_ADD:    state_d = ST_ADD;
						OP_REMOVE: state_d = ST_RM_CHK;
						default:   state_d = ST_WALK;
					endcase
				end
			end
			ST_ADD:    state_d = ST_DONE;
			ST_RM_CHK: state_d = slot_live ? ST_RM_UL : ST_DONE;
			ST_RM_UL:  state_d = ST_DONE;
			ST_WALK:   state_d = stop ? ST_DONE : ST_CHK;
			ST_CHK: begin
				if (!due) begin
					state_d = ST_DONE;
				end else if (can_emit) begin
					state_d = ST_WALK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		nx_we     = 1'b0;
		nx_re     = 1'b0;
		pv_we     = 1'b0;
		pv_re     = 1'b0;
		nx_waddr  = tail_q;
		nx_wdata  = free_idx_q;
		pv_waddr  = free_idx_q;
		pv_wdata  = tail_q;
		nx_raddr  = head_q;
		set_pend  = 1'b0;
		pend_d    = '0;
		push_mid  = 1'b0;
		push_last = 1'b0;
		add_go    = 1'b0;
		rm_go     = 1'b0;
		hd_go     = 1'b0;
		push_d    = pend_q;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			ST_ADD: begin
				set_pend = 1'b1;
				if (free_any_q) begin
					add_go            = 1'b1;
					mem_we            = 1'b1;
					nx_we             = !empty_q;
					pv_we             = !empty_q;
					pend_d.kind       = KIND_ADDED;
					pend_d.handle_res = free_h;
				end else begin
					pend_d.kind = KIND_ERROR;
				end
			end
			ST_RM_CHK: begin
				if (slot_live) begin
					nx_re    = 1'b1;
					pv_re    = 1'b1;
					nx_raddr = cmd_idx;
				end else begin
					set_pend          = 1'b1;
					pend_d.kind       = KIND_ERROR;
					pend_d.handle_res = cmd_q.handle;
				end
			end
			ST_RM_UL: begin
				rm_go             = 1'b1;
				set_pend          = 1'b1;
				pend_d.kind       = KIND_REMOVED;
				pend_d.handle_res = cmd_q.handle;
				// A slot in the middle: splice its neighbors together.
				if (cmd_idx != head_q && cmd_idx != tail_q) begin
					nx_we    = 1'b1;
					nx_waddr = pv_rd;
					nx_wdata = nx_rd;
					pv_we    = 1'b1;
					pv_waddr = nx_rd;
					pv_wdata = pv_rd;
				end
			end
			ST_WALK: begin
				if (!stop) begin
					mem_re = 1'b1;
					nx_re  = 1'b1;
				end
			end
			ST_CHK: begin
				if (due && can_emit) begin
					hd_go               = 1'b1;
					push_mid            = pend_v_q;
					set_pend            = 1'b1;
					pend_d.kind         = (cmd_q.op == OP_TICK) ? KIND_EXPIRED : KIND_CLEARED;
					pend_d.handle_res   = head_h;
					pend_d.user_arg_res = arg_rd;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					push_last = 1'b1;
					if (!pend_v_q) begin
						push_d      = '0;
						push_d.kind = KIND_NOTHING;
					end
					push_d.last = 1'b1;
				end
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			free_idx_q <= '0;
			free_any_q <= 1'b1;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			rsp_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_idx_q <= free_idx_d;
			free_any_q <= free_any_d;
			if (cmd_ready && cmd_valid) begin
				cnt_q <= '0;
			end
			if (add_go) begin
				valid_q[free_idx_q] <= 1'b1;
				tail_q              <= free_idx_q;
				empty_q             <= 1'b0;
				if (empty_q) begin
					head_q <= free_idx_q;
				end
			end
			if (rm_go) begin
				valid_q[cmd_idx] <= 1'b0;
				if (cmd_idx == head_q && cmd_idx == tail_q) begin
					empty_q <= 1'b1;
				end else if (cmd_idx == head_q) begin
					head_q <= nx_rd;
				end else if (cmd_idx == tail_q) begin
					tail_q <= pv_rd;
				end
			end
			if (hd_go) begin
				valid_q[head_q] <= 1'b0;
				cnt_q           <= cnt_q + CNT_W'(1);
				if (head_q == tail_q) begin
					empty_q <= 1'b1;
				end else begin
					head_q <= nx_rd;
				end
			end
			if (set_pend) begin
				pend_v_q <= 1'b1;
			end else if (push_last) begin
				pend_v_q <= 1'b0;
			end
			if (push_mid || push_last) begin
				rsp_v_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (set_pend) begin
			pend_q <= pend_d;
		end
		if (push_mid || push_last) begin
			rsp_q <= push_d;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

@@ sv/fixed_timeout_timer_list.sv @@
// Top level of the fixed-timeout timer list: front end, request queue, back end.
//
// A table of SLOTS timers that all share one delay, timeout_ticks, written
// through the cfg channel; the user must write it only while the block is idle,
// which the block does not enforce. Live timers form a doubly linked list in
// insertion order, which is deadline order while neither now nor the delay goes
// down. An add request stores now + timeout_ticks (wrapping at 64 bits) and the
// user argument in the lowest free slot and answers with that slot; a remove
// request unlinks any live slot; a tick request expires entries from the head
// while now is at or past their deadline; a clear request drains the whole list.
// Every request yields one or more results, the final one flagged by last, and
// at most 32 per request; entries beyond that stay linked for the next tick or
// clear. Timing: the front end registers each request and forms the deadline
// sum, then a two-entry queue decouples it from the back-end sequencer, so new
// requests are taken while the back end works or while a result waits on rsp.
// The back end handles one request at a time: an add passes ST_ADD, a remove
// ST_RM_CHK and, for a live slot, ST_RM_UL, and a tick or clear ST_WALK and
// ST_CHK per list step, as the slot memories are read through a register; all
// end in ST_DONE. Slot memories need no clearing pass after reset: an entry is
// only read once its valid bit says it was written.
`default_nettype none
module fixed_timeout_timer_list #(
	parameter int SLOTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ftl_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ftl_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ftl_pkg::TIMEOUT_W-1:0] cfg_data
);
	import ftl_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 f_in_valid, f_in_ready;
	logic                 f_out_valid, f_out_ready;
	cmd_t                 front_cmd, back_cmd;

	// The timeout register accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// The front end checks the handle range and adds the timeout once, so
	// the back end never sees the 64-bit sum on its own timing path.
	ftl_front #(.SLOTS(SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.timeout   (timeout_q),
		.cmd_valid (f_in_valid),
		.cmd_ready (f_in_ready),
		.cmd       (front_cmd)
	);

	// The queue lets the front end keep taking requests while a long
	// tick or clear walk is still draining in the back end.
	ftl_fifo #(.DEPTH(2)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_in_valid),
		.in_ready  (f_in_ready),
		.in_data   (front_cmd),
		.out_valid (f_out_valid),
		.out_ready (f_out_ready),
		.out_data  (back_cmd)
	);

	// The back end owns the slot memories, the valid bits and the list
	// pointers; it holds each result one step so that it can flag the last.
	ftl_back #(.SLOTS(SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (f_out_valid),
		.cmd_ready (f_out_ready),
		.cmd       (back_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);
endmodule
`default_nettype wire

@@ sv/ftl_checker.sv @@
// Port checker of the fixed-timeout timer list and its bind.
`default_nettype none
`include "fixed_timeout_timer_list_macros.svh"
module ftl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ftl_pkg::rsp_t rsp
);
	import ftl_pkg::*;

	logic       cont_q;
	logic [2:0] kind_q;

	// Tracks whether the last taken result left its request unfinished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 1'b0;
		end else if (rsp_valid && rsp_ready) begin
			cont_q <= !rsp.last;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			kind_q <= rsp.kind;
		end
	end

	`FTL_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	`FTL_ASSERT_IMP(a_nothing_empty, clk, arst_n, rsp_valid && rsp.kind == KIND_NOTHING, rsp.last && rsp.handle_res == '0 && rsp.user_arg_res == '0)
	`FTL_ASSERT_IMP(a_single_kinds, clk, arst_n, rsp_valid && (rsp.kind == KIND_ADDED || rsp.kind == KIND_REMOVED || rsp.kind == KIND_ERROR), rsp.last && rsp.user_arg_res == '0)
	`FTL_ASSERT_IMP(a_stream_kind, clk, arst_n, rsp_valid && cont_q, rsp.kind == kind_q && (rsp.kind == KIND_EXPIRED || rsp.kind == KIND_CLEARED))
endmodule

bind fixed_timeout_timer_list ftl_checker u_ftl_checker (.*);
`default_nettype wire

@@ test/timer_table_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard of the timer list testbench: a shadow timer table and the expected results.
package timer_table_sb_pkg;
	import ftl_pkg::*;

	localparam int SLOTS = 32;

	class timer_table_scoreboard;
		bit [TIMEOUT_W-1:0] timeout;
		bit                 live [SLOTS];
		bit [TIME_W-1:0]    deadline [SLOTS];
		bit [ARG_W-1:0]     arg [SLOTS];
		bit [HANDLE_W-1:0]  next_slot [SLOTS];
		bit [HANDLE_W-1:0]  prev_slot [SLOTS];
		bit [HANDLE_W-1:0]  head;
		bit [HANDLE_W-1:0]  tail;
		bit                 empty;
		rsp_t               expected_results [$];
		rsp_t               held;
		bit                 have_held;
		int unsigned        mismatch_count;

		function new();
			timeout = '0;
			head = '0;
			tail = '0;
			empty = 1'b1;
			mismatch_count = 0;
			foreach (live[i]) begin
				live[i] = 1'b0;
			end
		endfunction

		// The newest result is held back so that the final one of a request can take last.
		function void add_result(kind_t k, bit [HANDLE_W-1:0] h, bit [ARG_W-1:0] a);
			if (have_held) begin
				expected_results.insert(expected_results.size(), held);
			end
			held.kind = k;
			held.handle_res = h;
			held.user_arg_res = a;
			held.last = 1'b0;
			have_held = 1'b1;
		endfunction

		function void unlink(bit [HANDLE_W-1:0] s);
			if (s == head && s == tail) begin
				empty = 1'b1;
			end else if (s == head) begin
				head = next_slot[s];
			end else if (s == tail) begin
				tail = prev_slot[s];
			end else begin
				next_slot[prev_slot[s]] = next_slot[s];
				prev_slot[next_slot[s]] = prev_slot[s];
			end
			live[s] = 1'b0;
		endfunction

		// Applies one accepted request to the shadow table and queues its results.
		function void note_request(req_t r);
			int                free_slot;
			bit [HANDLE_W-1:0] s;
			int                n;
			kind_t             walk_kind;
			have_held = 1'b0;
			n = 0;
			case (r.opcode)
				OP_ADD: begin
					free_slot = -1;
					for (int i = SLOTS - 1; i >= 0; i--) begin
						if (!live[i]) free_slot = i;
					end
					if (free_slot < 0) begin
						add_result(KIND_ERROR, '0, '0);
					end else begin
						live[free_slot] = 1'b1;
						deadline[free_slot] = r.now + TIME_W'(timeout);
						arg[free_slot] = r.user_arg;
						if (empty) begin
							head = HANDLE_W'(free_slot);
							empty = 1'b0;
						end else begin
							next_slot[tail] = HANDLE_W'(free_slot);
							prev_slot[free_slot] = tail;
						end
						tail = HANDLE_W'(free_slot);
						add_result(KIND_ADDED, HANDLE_W'(free_slot), '0);
					end
				end
				OP_REMOVE: begin
					if (!live[r.handle]) begin
						add_result(KIND_ERROR, r.handle, '0);
					end else begin
						unlink(r.handle);
						add_result(KIND_REMOVED, r.handle, '0);
					end
				end
				default: begin
					walk_kind = (r.opcode == OP_TICK) ? KIND_EXPIRED : KIND_CLEARED;
					while (!empty && n < MAX_RESULTS) begin
						s = head;
						if (r.opcode == OP_TICK && r.now < deadline[s]) break;
						add_result(walk_kind, s, arg[s]);
						n++;
						unlink(s);
					end
					if (n == 0) begin
						add_result(KIND_NOTHING, '0, '0);
					end
				end
			endcase
			held.last = 1'b1;
			expected_results.insert(expected_results.size(), held);
		endfunction

		// Compares one accepted result with the oldest expected one.
		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d handle %0d",
					$time, got.kind, got.handle_res);
				$display("%0t: unexpected result arg %h last %0d",
					$time, got.user_arg_res, got.last);
				return;
			end
			want = expected_results.pop_front();
			if (got.kind !== want.kind) begin
				mismatch_count++;
				$display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, got.kind);
			end
			if (got.handle_res !== want.handle_res) begin
				mismatch_count++;
				$display("%0t: handle mismatch, expected %0d, actual %0d",
					$time, want.handle_res, got.handle_res);
			end
			if (got.user_arg_res !== want.user_arg_res) begin
				mismatch_count++;
				$display("%0t: user arg mismatch, expected %h, actual %h",
					$time, want.user_arg_res, got.user_arg_res);
			end
			if (got.last !== want.last) begin
				mismatch_count++;
				$display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last, got.last);
			end
		endfunction
	endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level testbench of the fixed-timeout timer list: stimulus, result sink and checking.
module tb_top;
	import ftl_pkg::*;
	import timer_table_sb_pkg::*;

	// How long the result side holds off once to make the block back up, and how
	// many cycles we let pass after the last result before calling the block idle.
	localparam int LONG_HOLD = 400;
	localparam int SETTLE    = 12;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TIMEOUT_W-1:0] cfg_data = '0;

	// When steady is set neither side inserts idle cycles. hold_results asks the
	// result sink for one long stall; the sink clears it once the stall is over.
	bit steady = 1'b0;
	bit hold_results = 1'b0;

	timer_table_scoreboard sb = new();

	fixed_timeout_timer_list #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Every handshake is observed here on the rising edge. All stimulus is driven
	// with nonblocking assignments, so this block always sees the values that were
	// present before the edge. A result can never come out at the same edge as the
	// request that caused it, so noting before checking is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) sb.note_request(req);
			if (rsp_valid && rsp_ready) sb.check_result(rsp);
			if (cfg_valid && cfg_ready) sb.timeout = cfg_data;
		end
	end

	// Hard stop in case the block hangs or loses a result.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic req_t make_req(op_t op, int unsigned h, logic [ARG_W-1:0] a,
			logic [TIME_W-1:0] t);
		req_t r;
		r.opcode = op;
		r.handle = HANDLE_W'(h);
		r.user_arg = a;
		r.now = t;
		return r;
	endfunction

	// Offers one request after a random gap and returns at the edge that accepts
	// it. With no gap, valid simply stays high into the next request.
	task automatic send_request(input req_t r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// The timeout register is only written while the block is idle.
	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering requests until every expected result has been seen. Every
	// request yields at least one result, so an empty queue means the back end is
	// done; the extra cycles cover the tail of its pipeline.
	task automatic wait_until_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One random phase with its own timeout. Time stamps mostly move forward in
	// steps scaled to the timeout, so adds and ticks line up and entries really
	// expire; a small share of requests are out-of-order times and random removes.
	task automatic run_phase(input logic [TIMEOUT_W-1:0] tmo, input logic [TIME_W-1:0] start,
			input int items, input bit with_hold);
		logic [TIME_W-1:0] timebase;
		logic [31:0]       step_max;
		int                pick;
		req_t              r;
		write_timeout(tmo);
		timebase = start;
		step_max = (tmo >> 3) + 32'd16;
		if (with_hold) begin
			steady = 1'b1;
			hold_results = 1'b1;
		end else begin
			steady = ($urandom_range(0, 3) == 0);
		end
		for (int i = 0; i < items; i++) begin
			timebase += TIME_W'($urandom_range(0, step_max));
			r = make_req(OP_ADD, $urandom, {$urandom, $urandom}, timebase);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// Plain add at the current time.
			end else if (pick < 65) begin
				r.opcode = OP_TICK;
			end else if (pick < 80) begin
				// Aim at a live timer when the shadow table has one to offer.
				r.opcode = OP_REMOVE;
				for (int k = 0; k < 8 && !sb.live[r.handle]; k++) r.handle = HANDLE_W'($urandom);
			end else if (pick < 85) begin
				r.opcode = OP_CLEAR;
			end else if (pick < 92) begin
				r.opcode = OP_REMOVE;
			end else if (pick < 97) begin
				r.opcode = OP_TICK;
				r.now = {$urandom, $urandom};
			end else begin
				// An add whose deadline breaks the time order of the list.
				r.now = {$urandom, $urandom};
			end
			send_request(r);
		end
		wait_until_idle();
		steady = 1'b0;
	endtask

	// Result sink: a random stall before each result, and once the long stall
	// that lets the request side back up.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
			end
			stall = steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : stimulus
		logic [TIME_W-1:0]    base;
		logic [TIMEOUT_W-1:0] tmo;
		logic [TIME_W-1:0]    start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with a timeout of 100: empty-table cases, errors,
		// removal from middle, tail and head, a deadline that wraps past 2^64 and
		// expiry exactly at the deadline.
		write_timeout(32'd100);
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom}, '0));
		send_request(make_req(OP_CLEAR, $urandom, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_REMOVE, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_REMOVE, 31, '1, '1));
		send_request(make_req(OP_ADD, 31, '0, 64'd0));
		send_request(make_req(OP_ADD, 0, '1, 64'd10));
		send_request(make_req(OP_ADD, $urandom, 64'hA5A5_A5A5_A5A5_A5A5, 64'd20));
		send_request(make_req(OP_ADD, $urandom, 64'h5A5A_5A5A_5A5A_5A5A, 64'd30));
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom}, 64'd99));
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom}, 64'd100));
		send_request(make_req(OP_REMOVE, 2, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_REMOVE, 3, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_ADD, $urandom, {$urandom, $urandom}, 64'd40));
		send_request(make_req(OP_REMOVE, 1, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_ADD, $urandom, {$urandom, $urandom}, '1));
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom}, '1));
		send_request(make_req(OP_ADD, $urandom, {$urandom, $urandom}, 64'd0));
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom}, 64'd100));
		send_request(make_req(OP_REMOVE, 0, {$urandom, $urandom}, {$urandom, $urandom}));
		wait_until_idle();

		// Full table with a zero timeout: one add too many, a tick that expires all
		// 32 entries at once, then a refill drained by a clear and a clear of the
		// empty table.
		write_timeout('0);
		base = {$urandom, $urandom} >> 1;
		for (int i = 0; i <= SLOTS; i++) begin
			send_request(make_req(OP_ADD, $urandom, {$urandom, $urandom}, base + TIME_W'(i)));
		end
		send_request(make_req(OP_TICK, $urandom, {$urandom, $urandom},
			base + TIME_W'(SLOTS - 1)));
		for (int i = 0; i < SLOTS; i++) begin
			send_request(make_req(OP_ADD, $urandom, {$urandom, $urandom}, {$urandom, $urandom}));
		end
		send_request(make_req(OP_CLEAR, $urandom, {$urandom, $urandom}, {$urandom, $urandom}));
		send_request(make_req(OP_CLEAR, $urandom, {$urandom, $urandom}, {$urandom, $urandom}));
		wait_until_idle();

		// Random phases: largest timeout near the time wrap, zero timeout, a tiny
		// one, the phase with the long result stall, then mixed settings.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					tmo = '1;
					start = 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, $urandom};
				end
				1: begin
					tmo = '0;
					start = {$urandom, $urandom};
				end
				2: begin
					tmo = $urandom_range(1, 64);
					start = '0;
				end
				3: begin
					tmo = $urandom_range(16, 500);
					start = {$urandom, $urandom};
				end
				default: begin
					tmo = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
					start = $urandom_range(0, 1) ? {$urandom, $urandom} :
						64'hFFFF_FFFF_FFFF_FFFF - {32'd0, $urandom_range(0, 5000)};
				end
			endcase
			run_phase(tmo, start, 36, p == 3);
		end

		if (sb.mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ftl_pkg.sv
sv/ftl_ram.sv
sv/ftl_front.sv
sv/ftl_fifo.sv
sv/ftl_back.sv
sv/fixed_timeout_timer_list.sv
sv/ftl_checker.sv
test/timer_table_scoreboard.sv
test/tb_top.sv
